// ===== sv/olid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and codes for the ordered list with positional insert/delete.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int WORD_W   = 32;
  localparam int LANE_MAX = 32;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_POP      = 3'd1,
    OP_INSERT   = 3'd2,
    OP_DELETE   = 3'd3,
    OP_CONTAINS = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_POS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_WRITE,
    CM_INS,
    CM_DEL
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       capture;
    logic       rd_en;
    logic       scan_en;
  } cell_ctl_t;

endpackage

// ===== sv/olid_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_cell
// One list slot: holds a word, shifts with its neighbours, and keeps a result
// word and hit flag that drain along the row after each item.
// ----------------------------------------------------------------------------
module olid_cell
  import olid_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int CELL_INDEX = 0
) (
  input  logic                             clk,
  input  cell_ctl_t                        ctl,
  input  logic [$clog2(DEPTH + 1) - 1:0]   tgt,
  input  logic [$clog2(DEPTH + 1) - 1:0]   cnt,
  input  logic [WORD_W - 1:0]              val,
  input  logic [WORD_W - 1:0]              left_data,
  input  logic [WORD_W - 1:0]              right_data,
  input  logic [WORD_W - 1:0]              res_in_data,
  input  logic                             res_in_hit,
  output logic [WORD_W - 1:0]              data,
  output logic [WORD_W - 1:0]              res_data,
  output logic                             res_hit
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam logic [IW - 1:0] IDX = IW'(CELL_INDEX);

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CM_HOLD: ;
      CM_WRITE: begin
        if (IDX == tgt) data <= val;
      end
      CM_INS: begin
        if (IDX == tgt) data <= val;
        else if (IDX > tgt) data <= left_data;
      end
      CM_DEL: begin
        if (IDX >= tgt) data <= right_data;
      end
      default: ;
    endcase

    if (ctl.capture) begin
      res_data <= (ctl.rd_en && IDX == tgt) ? data : '0;
      res_hit  <= ctl.scan_en && (IDX < cnt) && (data == val);
    end else begin
      res_data <= res_in_data;
      res_hit  <= res_in_hit;
    end
  end

endmodule

// ===== sv/ordered_list_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed words held in a row of cells, with append, pop,
// positional insert and delete, and a membership test.
//
//   channel | valid     | stall     | fields
//   --------+-----------+-----------+------------------------------------------
//   req     | req_valid | req_stall | opcode, position, value
//   rsp     | rsp_valid | rsp_stall | result_value, found, status, entry_count
//
// One item in flight. The list update happens at the accept edge; the result
// is then drained from the row, up to 32 cells per cycle, in S_SCAN and then
// held in S_OUT; no new item is accepted until rsp has taken the result.
// Reset clears the count and the handshake state; slot contents are not reset.
// req_stall is high during reset and until the result item has been taken.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [2:0]          opcode,
  input  logic [5:0]          position,
  input  logic signed [31:0]  value,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic signed [31:0]  result_value,
  output logic                found,
  output logic [1:0]          status,
  output logic [5:0]          entry_count
);

  localparam int IW     = $clog2(DEPTH + 1);
  localparam int CW     = (IW > 6) ? IW : 6;
  localparam int LANE   = (DEPTH < LANE_MAX) ? DEPTH : LANE_MAX;
  localparam int GROUPS = (DEPTH + LANE - 1) / LANE;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  state_t             state;
  logic [IW - 1:0]    count;
  logic [IW - 1:0]    count_next;
  logic [IW - 1:0]    tgt;
  status_t            st;
  status_t            st_q;
  cell_mode_t         mode;
  cell_ctl_t          ctl;
  logic [GW - 1:0]    scan_left;
  logic [WORD_W - 1:0] acc_data;
  logic               acc_hit;
  logic [WORD_W - 1:0] lane_data;
  logic               lane_hit;
  logic               req_acc;
  logic               is_full;
  logic               is_empty;
  logic [CW - 1:0]    pos_w;
  logic [CW - 1:0]    cnt_w;

  logic [WORD_W - 1:0] cell_data [DEPTH];
  logic [WORD_W - 1:0] cell_res  [DEPTH];
  logic                cell_hit  [DEPTH];

  assign req_stall = rst || (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign is_full   = (count == IW'(DEPTH));
  assign is_empty  = (count == '0);
  assign pos_w     = CW'(position);
  assign cnt_w     = CW'(count);

  always_comb begin
    mode       = CM_HOLD;
    st         = ST_OK;
    count_next = count;
    tgt        = '0;
    ctl        = '0;
    unique case (opcode_t'(opcode))
      OP_APPEND: begin
        if (is_full) st = ST_FULL;
        else begin
          mode       = CM_WRITE;
          tgt        = count;
          count_next = count + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty) st = ST_EMPTY;
        else begin
          ctl.rd_en  = 1'b1;
          tgt        = count - 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_INSERT: begin
        if (is_full) st = ST_FULL;
        else if (pos_w > cnt_w) st = ST_POS;
        else begin
          mode       = CM_INS;
          tgt        = IW'(position);
          count_next = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (is_empty) st = ST_EMPTY;
        else if (pos_w >= cnt_w) st = ST_POS;
        else begin
          mode       = CM_DEL;
          ctl.rd_en  = 1'b1;
          tgt        = IW'(position);
          count_next = count - 1'b1;
        end
      end
      OP_CONTAINS: ctl.scan_en = 1'b1;
      default: ;
    endcase
    ctl.capture = req_acc;
    ctl.mode    = req_acc ? mode : CM_HOLD;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W - 1:0] left_d;
    logic [WORD_W - 1:0] right_d;
    logic [WORD_W - 1:0] rin_d;
    logic                rin_h;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[i - 1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i + 1];
    end

    if (i + LANE < DEPTH) begin : g_feed
      assign rin_d = cell_res[i + LANE];
      assign rin_h = cell_hit[i + LANE];
    end else begin : g_tail
      assign rin_d = '0;
      assign rin_h = 1'b0;
    end

    olid_cell #(
      .DEPTH      (DEPTH),
      .CELL_INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .tgt         (tgt),
      .cnt         (count),
      .val         (value),
      .left_data   (left_d),
      .right_data  (right_d),
      .res_in_data (rin_d),
      .res_in_hit  (rin_h),
      .data        (cell_data[i]),
      .res_data    (cell_res[i]),
      .res_hit     (cell_hit[i])
    );
  end

  always_comb begin
    lane_data = '0;
    lane_hit  = 1'b0;
    for (int l = 0; l < LANE; l++) begin
      lane_data = lane_data | cell_res[l];
      lane_hit  = lane_hit | cell_hit[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            count     <= count_next;
            st_q      <= st;
            acc_data  <= '0;
            acc_hit   <= 1'b0;
            scan_left <= GW'(GROUPS - 1);
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          acc_data <= acc_data | lane_data;
          acc_hit  <= acc_hit | lane_hit;
          if (scan_left == '0) begin
            result_value <= acc_data | lane_data;
            found        <= acc_hit | lane_hit;
            status       <= st_q;
            entry_count  <= 6'(count);
            rsp_valid    <= 1'b1;
            state        <= S_OUT;
          end else begin
            scan_left <= scan_left - 1'b1;
          end
        end
        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
